/* hdl/signed_int_to_decimal_ascii_macros.svh */
`ifndef SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH
`define SIGNED_INT_TO_DECIMAL_ASCII_MACROS_SVH

// Same-cycle implication, checked on every clock edge outside reset.
`define S2D_ASSERT_NOW(label, cond, conseq, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |-> (conseq)) \
      else $error(msg);

// Next-cycle implication, checked on every clock edge outside reset.
`define S2D_ASSERT_NEXT(label, cond, conseq, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond) |=> (conseq)) \
      else $error(msg);

`endif

/* hdl/s2d_pkg.sv */
`default_nettype none

package s2d_pkg;

   localparam int VALUE_WIDTH_DEFAULT = 32;
   localparam int DIGIT_BITS = 4;
   localparam int STEP_BITS = 4;
   localparam int CHAR_WIDTH = 8;

   localparam logic [DIGIT_BITS-1:0] DABBLE_LIMIT = 4'd5;
   localparam logic [DIGIT_BITS-1:0] DABBLE_ADJUST = 4'd3;
   localparam logic [CHAR_WIDTH-1:0] CHAR_ZERO = 8'h30;
   localparam logic [CHAR_WIDTH-1:0] CHAR_MINUS = 8'h2D;

   // Number of decimal digits of the largest magnitude, 2^(width-1).
   function automatic int num_digits(input int width);
      longint unsigned m;
      int n;
      m = 64'd1 << (width - 1);
      n = 1;
      while (m >= 64'd10) begin
         m = m / 64'd10;
         n = n + 1;
      end
      return n;
   endfunction

endpackage

`default_nettype wire

/* hdl/s2d_dabble.sv */
`default_nettype none

module s2d_dabble #(
   parameter int MAG_WIDTH = 32,
   parameter int DIGITS = 10
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  enable,
   input  wire logic                                  src_valid,
   input  wire logic [DIGITS*s2d_pkg::DIGIT_BITS-1:0] src_bcd,
   input  wire logic [MAG_WIDTH-1:0]                  src_mag,
   input  wire logic                                  src_neg,
   output logic                                       dst_valid,
   output logic [DIGITS*s2d_pkg::DIGIT_BITS-1:0]      dst_bcd,
   output logic [MAG_WIDTH-1:0]                       dst_mag,
   output logic                                       dst_neg
);
   import s2d_pkg::*;

   localparam int BcdWidth = DIGITS * DIGIT_BITS;

   logic                 valid_ff;
   logic [BcdWidth-1:0]  bcd_ff;
   logic [BcdWidth-1:0]  bcd_in;
   logic [MAG_WIDTH-1:0] mag_ff;
   logic [MAG_WIDTH-1:0] mag_in;
   logic                 neg_ff;

   // Each step corrects every digit of five or more, then shifts in the next bit.
   always_comb begin
      bcd_in = src_bcd;
      mag_in = src_mag;
      for (int s = 0; s < STEP_BITS; s++) begin
         for (int d = 0; d < DIGITS; d++) begin
            if (bcd_in[d*DIGIT_BITS +: DIGIT_BITS] >= DABBLE_LIMIT) begin
               bcd_in[d*DIGIT_BITS +: DIGIT_BITS] =
                  bcd_in[d*DIGIT_BITS +: DIGIT_BITS] + DABBLE_ADJUST;
            end
         end
         bcd_in = {bcd_in[BcdWidth-2:0], mag_in[MAG_WIDTH-1]};
         mag_in = {mag_in[MAG_WIDTH-2:0], 1'b0};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (enable) begin
         valid_ff <= src_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (enable) begin
         bcd_ff <= bcd_in;
         mag_ff <= mag_in;
         neg_ff <= src_neg;
      end
   end

   assign dst_valid = valid_ff;
   assign dst_bcd = bcd_ff;
   assign dst_mag = mag_ff;
   assign dst_neg = neg_ff;

endmodule

`default_nettype wire

/* hdl/signed_int_to_decimal_ascii.sv */
// Converts a signed integer to its decimal text, one ASCII character per cycle on
// rsp_character, most significant first: '-' for a negative value, then the digits
// without leading zeros ('0' for zero); rsp_last marks the final character of an item.
// An item is taken when start is high and busy is low. The magnitude passes through
// ceil(VALUE_WIDTH/4) shift-and-add-3 stages, four bits each, and a digit-count stage,
// then a serializer drives one character per cycle. The one-character result port
// sets the rate: an item holds it until all of its characters, from 1 to 11 at the
// default width, have left, and the items of a stream leave without gaps between
// them. Results cannot be held off: each stays on the ports for one cycle only.
`default_nettype none

`include "signed_int_to_decimal_ascii_macros.svh"

module signed_int_to_decimal_ascii #(
   parameter int VALUE_WIDTH = s2d_pkg::VALUE_WIDTH_DEFAULT
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire logic signed [VALUE_WIDTH-1:0]     req_value,
   output logic                                   rsp_valid,
   output logic [s2d_pkg::CHAR_WIDTH-1:0]         rsp_character,
   output logic                                   rsp_last
);
   import s2d_pkg::*;

   localparam int NumDigits = num_digits(VALUE_WIDTH);
   localparam int Stages = (VALUE_WIDTH + STEP_BITS - 1) / STEP_BITS;
   localparam int MagWidth = Stages * STEP_BITS;
   localparam int BcdWidth = NumDigits * DIGIT_BITS;
   localparam int PosWidth = $clog2(NumDigits);

   logic                   advance;
   logic                   load_ok;
   logic                   load;

   logic [VALUE_WIDTH-1:0] raw;
   logic [VALUE_WIDTH-1:0] magnitude;
   logic                   entry_valid_ff;
   logic [MagWidth-1:0]    entry_mag_ff;
   logic                   entry_neg_ff;

   logic                   stage_valid [0:Stages];
   logic [BcdWidth-1:0]    stage_bcd [0:Stages];
   logic [MagWidth-1:0]    stage_mag [0:Stages];
   logic                   stage_neg [0:Stages];

   logic                   cnt_valid_ff;
   logic [BcdWidth-1:0]    cnt_bcd_ff;
   logic                   cnt_neg_ff;
   logic [PosWidth-1:0]    cnt_top_ff;
   logic [PosWidth-1:0]    cnt_top_in;

   logic                   ser_active_ff;
   logic                   ser_active_in;
   logic                   ser_minus_ff;
   logic                   ser_minus_in;
   logic [PosWidth-1:0]    ser_pos_ff;
   logic [PosWidth-1:0]    ser_pos_in;
   logic [DIGIT_BITS-1:0]  ser_digits_ff [0:NumDigits-1];
   logic [DIGIT_BITS-1:0]  ser_digits_in [0:NumDigits-1];
   logic                   ser_finish;
   logic [CHAR_WIDTH-1:0]  emit_char;
   logic                   emit_last;

   logic                   rsp_valid_ff;
   logic [CHAR_WIDTH-1:0]  rsp_character_ff;
   logic                   rsp_last_ff;

   // The whole conversion pipeline moves together; it halts only when the
   // counted item cannot yet pass to the serializer.
   assign ser_finish = ser_active_ff && !ser_minus_ff && (ser_pos_ff == '0);
   assign load_ok = !ser_active_ff || ser_finish;
   assign advance = !cnt_valid_ff || load_ok;
   assign load = cnt_valid_ff && load_ok;
   assign busy = !advance;

   assign raw = req_value;
   assign magnitude = raw[VALUE_WIDTH-1] ? (~raw + VALUE_WIDTH'(1)) : raw;

   always_ff @(posedge clock) begin
      if (reset) begin
         entry_valid_ff <= 1'b0;
      end else if (advance) begin
         entry_valid_ff <= start;
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         entry_mag_ff <= MagWidth'(magnitude);
         entry_neg_ff <= raw[VALUE_WIDTH-1];
      end
   end

   assign stage_valid[0] = entry_valid_ff;
   assign stage_bcd[0] = '0;
   assign stage_mag[0] = entry_mag_ff;
   assign stage_neg[0] = entry_neg_ff;

   for (genvar k = 0; k < Stages; k++) begin : g_dabble
      s2d_dabble #(
         .MAG_WIDTH (MagWidth),
         .DIGITS    (NumDigits)
      ) u_dabble (
         .clock     (clock),
         .reset     (reset),
         .enable    (advance),
         .src_valid (stage_valid[k]),
         .src_bcd   (stage_bcd[k]),
         .src_mag   (stage_mag[k]),
         .src_neg   (stage_neg[k]),
         .dst_valid (stage_valid[k+1]),
         .dst_bcd   (stage_bcd[k+1]),
         .dst_mag   (stage_mag[k+1]),
         .dst_neg   (stage_neg[k+1])
      );
   end

   // The top digit position is the highest nonzero digit, or the lowest one for zero.
   always_comb begin
      cnt_top_in = '0;
      for (int d = 1; d < NumDigits; d++) begin
         if (stage_bcd[Stages][d*DIGIT_BITS +: DIGIT_BITS] != '0) begin
            cnt_top_in = PosWidth'(d);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_valid_ff <= 1'b0;
      end else if (advance) begin
         cnt_valid_ff <= stage_valid[Stages];
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         cnt_bcd_ff <= stage_bcd[Stages];
         cnt_neg_ff <= stage_neg[Stages];
         cnt_top_ff <= cnt_top_in;
      end
   end

   assign emit_char = ser_minus_ff ? CHAR_MINUS
                                   : CHAR_ZERO + CHAR_WIDTH'(ser_digits_ff[ser_pos_ff]);
   assign emit_last = ser_finish;

   always_comb begin
      ser_active_in = ser_active_ff && !ser_finish;
      ser_minus_in = ser_minus_ff;
      ser_pos_in = ser_pos_ff;
      ser_digits_in = ser_digits_ff;
      if (ser_active_ff) begin
         if (ser_minus_ff) begin
            ser_minus_in = 1'b0;
         end else if (ser_pos_ff != '0) begin
            ser_pos_in = ser_pos_ff - PosWidth'(1);
         end
      end
      if (load) begin
         ser_active_in = 1'b1;
         ser_minus_in = cnt_neg_ff;
         ser_pos_in = cnt_top_ff;
         for (int d = 0; d < NumDigits; d++) begin
            ser_digits_in[d] = cnt_bcd_ff[d*DIGIT_BITS +: DIGIT_BITS];
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ser_active_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         ser_active_ff <= ser_active_in;
         rsp_valid_ff <= ser_active_ff;
      end
   end

   always_ff @(posedge clock) begin
      ser_minus_ff <= ser_minus_in;
      ser_pos_ff <= ser_pos_in;
      ser_digits_ff <= ser_digits_in;
      rsp_character_ff <= emit_char;
      rsp_last_ff <= emit_last;
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_character = rsp_character_ff;
   assign rsp_last = rsp_last_ff;

   `S2D_ASSERT_NOW(a_mag_drained, stage_valid[Stages], stage_mag[Stages] == '0,
      "Magnitude bits remain after the last conversion stage.")
   `S2D_ASSERT_NEXT(a_no_gap, rsp_valid && !rsp_last, rsp_valid,
      "The characters of an item are not contiguous.")
   `S2D_ASSERT_NOW(a_minus_not_last, rsp_valid && (rsp_character == CHAR_MINUS), !rsp_last,
      "A minus sign is marked as the final character.")

endmodule

`default_nettype wire

/* dv/tb_signed_int_to_decimal_ascii.sv */
`timescale 1ns / 1ps

module tb_signed_int_to_decimal_ascii;
   import s2d_pkg::*;

   localparam int WIDTH = 32;
   localparam int N_DIRECTED = 18;
   localparam int N_RANDOM_PER_PHASE = 62;
   localparam int N_PHASES = 5;
   localparam int DRAIN_LIMIT = 5000;
   localparam int SETTLE_CYCLES = 40;

   typedef struct packed {
      logic [CHAR_WIDTH-1:0] code;
      logic                  last;
   } text_char_type;

   logic                    clock = 1'b0;
   logic                    reset = 1'b1;
   logic                    start = 1'b0;
   logic signed [WIDTH-1:0] req_value = '0;
   logic                    busy;
   logic                    rsp_valid;
   logic [CHAR_WIDTH-1:0]   rsp_character;
   logic                    rsp_last;

   text_char_type pending_chars[$];
   int            mismatch_count = 0;

   logic signed [WIDTH-1:0] directed_values [N_DIRECTED] = '{
      32'sd0, 32'sd1, -32'sd1, 32'sd9, 32'sd10, -32'sd10,
      32'sh7FFF_FFFF, 32'sh8000_0000, -32'sd2147483647, 32'sd1000000000,
      32'sd999999999, -32'sd999999999, 32'sh5555_5555, 32'shAAAA_AAAA,
      32'sd99, 32'sd100, -32'sd100000, 32'sd12345
   };
   string directed_texts [N_DIRECTED] = '{
      "0", "1", "-1", "9", "10", "-10",
      "2147483647", "-2147483648", "-2147483647", "1000000000",
      "", "", "", "", "", "", "", ""
   };
   int phase_idle_pct [N_PHASES] = '{0, 81, 16, 0, 81};

   always #10 clock = ~clock;

   signed_int_to_decimal_ascii #(
      .VALUE_WIDTH(WIDTH)
   ) uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_value(req_value),
      .rsp_valid(rsp_valid),
      .rsp_character(rsp_character),
      .rsp_last(rsp_last)
   );

   task automatic report_mismatch(input string what);
      mismatch_count++;
      if (mismatch_count <= 40) begin
         $display("ERROR at %0d ns: %s", $time, what);
      end
   endtask

   function automatic void push_decimal_text(input logic signed [WIDTH-1:0] value);
      logic [WIDTH:0]        magnitude;
      logic [CHAR_WIDTH-1:0] digit_codes [0:23];
      int                    count;
      int                    k;
      magnitude = value[WIDTH-1] ? ((WIDTH+1)'(0) - {value[WIDTH-1], value})
                                 : {1'b0, value};
      count = 0;
      do begin
         digit_codes[count] = CHAR_ZERO + CHAR_WIDTH'(magnitude % (WIDTH+1)'(10));
         count++;
         magnitude = magnitude / (WIDTH+1)'(10);
      end while (magnitude != 0);
      if (value[WIDTH-1]) begin
         pending_chars.push_back('{code: CHAR_MINUS, last: 1'b0});
      end
      for (k = count - 1; k >= 0; k--) begin
         pending_chars.push_back('{code: digit_codes[k], last: (k == 0)});
      end
   endfunction

   function automatic void push_typed_text(input string text);
      int i;
      for (i = 0; i < text.len(); i++) begin
         pending_chars.push_back('{code: CHAR_WIDTH'(text[i]), last: (i == text.len() - 1)});
      end
   endfunction

   function automatic logic signed [WIDTH-1:0] random_value();
      logic signed [WIDTH-1:0] v;
      longint unsigned         limit;
      longint unsigned         m;
      int                      n;
      int                      i;
      case ($urandom_range(9))
         0: begin
            v = $urandom;
         end
         1: begin
            v = 32'sh8000_0000 + $urandom_range(3);
         end
         2: begin
            v = 32'sh7FFF_FFFF - $urandom_range(3);
         end
         3: begin
            limit = 1;
            n = $urandom_range(9);
            for (i = 0; i < n; i++) begin
               limit = limit * 10;
            end
            v = WIDTH'(limit) + $urandom_range(2) - 1;
            if ($urandom_range(1)) begin
               v = -v;
            end
         end
         default: begin
            limit = 1;
            n = $urandom_range(1, 10);
            for (i = 0; i < n; i++) begin
               limit = limit * 10;
            end
            m = {$urandom, $urandom};
            v = WIDTH'(m % limit);
            if ($urandom_range(1)) begin
               v = -v;
            end
         end
      endcase
      return v;
   endfunction

   // Returns at the clock edge that accepts the item, with start still high.
   task automatic offer_item(input logic signed [WIDTH-1:0] value, input int idle_pct);
      while ($urandom_range(99) < idle_pct) begin
         start <= 1'b0;
         @(posedge clock);
      end
      start <= 1'b1;
      req_value <= value;
      do begin
         @(posedge clock);
      end while (busy);
   endtask

   always @(posedge clock) begin
      text_char_type wanted;
      if (!reset && rsp_valid) begin
         if (pending_chars.size() == 0) begin
            report_mismatch($sformatf("unexpected character 0x%02h last=%0b",
                                      rsp_character, rsp_last));
         end else begin
            wanted = pending_chars.pop_front();
            if (rsp_character !== wanted.code) begin
               report_mismatch($sformatf("character 0x%02h, expected 0x%02h",
                                         rsp_character, wanted.code));
            end
            if (rsp_last !== wanted.last) begin
               report_mismatch($sformatf("last %0b, expected %0b on character 0x%02h",
                                         rsp_last, wanted.last, wanted.code));
            end
         end
      end
   end

   initial begin
      logic signed [WIDTH-1:0] v;
      int                      p;
      int                      i;
      int                      waited;
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (i = 0; i < N_DIRECTED; i++) begin
         offer_item(directed_values[i], 0);
         if (directed_texts[i].len() != 0) begin
            push_typed_text(directed_texts[i]);
         end else begin
            push_decimal_text(directed_values[i]);
         end
      end
      for (p = 0; p < N_PHASES; p++) begin
         for (i = 0; i < N_RANDOM_PER_PHASE; i++) begin
            v = random_value();
            offer_item(v, phase_idle_pct[p]);
            push_decimal_text(v);
         end
      end
      start <= 1'b0;
      waited = 0;
      while (pending_chars.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
      if (pending_chars.size() != 0) begin
         report_mismatch($sformatf("%0d expected characters never arrived",
                                   pending_chars.size()));
      end
      if (mismatch_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

   initial begin
      #20_000_000;
      $display("[FAIL] regression broken");
      $finish;
   end

endmodule
